### rtl/psbh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psbh_pkg - types and constants for the projectile step / swept box tester
// Command codes, register indexes, field widths and the word structs.
// ----------------------------------------------------------------------------
package psbh_pkg;

	localparam int POS_W      = 24;
	localparam int PIX_W      = 17;   // rounded pixel coordinate
	localparam int DIF_W      = 18;   // difference of two pixel coordinates
	localparam int REG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int POS_FRAC   = 8;
	localparam int DIR_FRAC   = 14;
	localparam int MAG_W      = 18;   // serial multiplier operand, signed
	localparam int A_W        = 27;   // parallel multiplicand, signed
	localparam int PROD_W     = 45;
	localparam int PROD_N     = 6;
	localparam int OP_W       = 3;

	localparam logic [1:0] CMD_LAUNCH  = 2'd0;
	localparam logic [1:0] CMD_ADVANCE = 2'd1;
	localparam logic [1:0] CMD_TEST    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BOUND_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd6;

	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [POS_W-1:0] start_x;
		logic signed [POS_W-1:0] start_y;
		logic [9:0]              elapsed;
		logic signed [REG_W-1:0] box_left;
		logic signed [REG_W-1:0] box_top;
		logic signed [REG_W-1:0] box_right;
		logic signed [REG_W-1:0] box_bottom;
	} item_t;

	typedef struct packed {
		logic                    is_active;
		logic                    hit;
		logic signed [POS_W-1:0] at_x;
		logic signed [POS_W-1:0] at_y;
	} result_t;

endpackage
`default_nettype wire

### rtl/projectile_step_and_swept_box_hit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// projectile_step_and_swept_box_hit - single projectile tracker
// Launch / advance / swept segment versus box test, products on one
// bit-serial shift-add multiplier.
//
//   port group                dir   timing
//   start, busy, item         in    word taken when start && !busy
//   done, result              out   word valid for the one cycle done is high
//   cfg_we, cfg_idx, cfg_data in    register written when cfg_we is high
//
// Launch, idle advance and unused commands: result in the cycle after accept.
// Advance: 3 products, each a load and a shift-add run, plus finish.
// Test: prep, 6 products and finish.
// Reset clears state and registers to zero; no clearing pass.
// The receiver cannot stall, busy is the only back pressure.
// ----------------------------------------------------------------------------
module projectile_step_and_swept_box_hit
	import psbh_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire item_t                item,
	output logic                      done,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [REG_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic signed [31:0] SAT_MAX = 32'sd8388607;
	localparam logic signed [31:0] SAT_MIN = -32'sd8388608;

	logic [2:0] state_q;
	item_t      item_q;

	logic signed [REG_W-1:0] bnd_l_q, bnd_t_q, bnd_r_q, bnd_b_q, dir_x_q, dir_y_q;
	logic [REG_W-1:0]        speed_q;

	logic                    alive_q;
	logic signed [POS_W-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;

	logic signed [DIF_W-1:0] bx_q, by_q, dyt_q, dyb_q, dxl_q, dxr_q;
	logic signed [PIX_W-1:0] w_q, h_q;

	logic signed [PROD_W-1:0] p_q [PROD_N];
	logic [OP_W-1:0]          op_q;
	logic signed [47:0]       mcand_q, acc_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic [4:0]               cnt_q;

	logic done_q;
	result_t res_q;

	function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [POS_W-1:0] v);
		logic signed [POS_W:0] t;
		logic [POS_W:0]        m;
		logic [POS_W:0]        q;
		t = (POS_W+1)'(v) + (POS_W+1)'(1 << (POS_FRAC - 1));
		m = t[POS_W] ? -t : t;
		q = m >> POS_FRAC;
		return t[POS_W] ? PIX_W'(-q) : PIX_W'(q);
	endfunction

	function automatic logic in_closed(input logic signed [PROD_W:0] n,
	                                   input logic signed [PROD_W:0] d);
		return (d > 0) ? (n >= 0 && n <= d) : (n <= 0 && n >= d);
	endfunction

	// operand select for the serial multiplier
	logic signed [A_W-1:0]   op_a;
	logic signed [MAG_W-1:0] op_b;
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (item_q.cmd == CMD_ADVANCE) begin
			case (op_q)
				3'd0: begin
					op_a = $signed({{(A_W-REG_W){1'b0}}, speed_q});
					op_b = $signed({{(MAG_W-10){1'b0}}, item_q.elapsed});
				end
				3'd1: begin
					op_a = p_q[0][A_W-1:0];
					op_b = MAG_W'(dir_x_q);
				end
				default: begin
					op_a = p_q[0][A_W-1:0];
					op_b = MAG_W'(dir_y_q);
				end
			endcase
		end else begin
			case (op_q)
				3'd0: begin op_a = A_W'(dyt_q); op_b = bx_q; end
				3'd1: begin op_a = A_W'(dyb_q); op_b = bx_q; end
				3'd2: begin op_a = A_W'(dxl_q); op_b = by_q; end
				3'd3: begin op_a = A_W'(dxr_q); op_b = by_q; end
				3'd4: begin op_a = A_W'(by_q);  op_b = MAG_W'(w_q); end
				default: begin op_a = A_W'(bx_q); op_b = MAG_W'(h_q); end
			endcase
		end
	end

	logic signed [47:0] acc_nx;
	logic [OP_W-1:0]    op_last;
	assign acc_nx  = acc_q + (mag_q[0] ? mcand_q : 48'sd0);
	assign op_last = (item_q.cmd == CMD_ADVANCE) ? OP_W'(2) : OP_W'(PROD_N - 1);

	// advance finish
	logic signed [31:0]      sx, sy, nx, ny;
	logic signed [POS_W-1:0] nx_sat, ny_sat;
	logic                    out_of_bounds;
	always_comb begin
		sx = 32'(p_q[1] >>> DIR_FRAC);
		sy = 32'(p_q[2] >>> DIR_FRAC);
		nx = 32'(cur_x_q) + sx;
		ny = 32'(cur_y_q) + sy;
		nx_sat = (nx > SAT_MAX) ? POS_W'(SAT_MAX) : (nx < SAT_MIN) ? POS_W'(SAT_MIN) : POS_W'(nx);
		ny_sat = (ny > SAT_MAX) ? POS_W'(SAT_MAX) : (ny < SAT_MIN) ? POS_W'(SAT_MIN) : POS_W'(ny);
		out_of_bounds = (nx_sat < $signed({bnd_l_q, {POS_FRAC{1'b0}}})) ||
		                (nx_sat > $signed({bnd_r_q, {POS_FRAC{1'b0}}})) ||
		                (ny_sat < $signed({bnd_t_q, {POS_FRAC{1'b0}}})) ||
		                (ny_sat > $signed({bnd_b_q, {POS_FRAC{1'b0}}}));
	end

	// test finish: axis aligned edges reduce n0/den to a plain ratio
	logic signed [PROD_W:0] n_ac, n_bc, n_ad, den_h, den_v;
	logic signed [PROD_W:0] ratio_t, ratio_b, ratio_l, ratio_r, neg_by, bx_w;
	logic                   hit_c;
	always_comb begin
		n_ac    = (PROD_W+1)'(p_q[0]) - (PROD_W+1)'(p_q[2]);
		n_bc    = (PROD_W+1)'(p_q[1]) - (PROD_W+1)'(p_q[2]);
		n_ad    = (PROD_W+1)'(p_q[0]) - (PROD_W+1)'(p_q[3]);
		den_h   = -(PROD_W+1)'(p_q[4]);
		den_v   = (PROD_W+1)'(p_q[5]);
		neg_by  = -(PROD_W+1)'(by_q);
		bx_w    = (PROD_W+1)'(bx_q);
		ratio_t = (PROD_W+1)'(dyt_q);
		ratio_b = (PROD_W+1)'(dyb_q);
		ratio_l = -(PROD_W+1)'(dxl_q);
		ratio_r = -(PROD_W+1)'(dxr_q);
		hit_c = ((den_h != 0) && in_closed(ratio_t, neg_by) && in_closed(n_ac, den_h)) ||
		        ((den_h != 0) && in_closed(ratio_b, neg_by) && in_closed(n_bc, den_h)) ||
		        ((den_v != 0) && in_closed(ratio_l, bx_w) && in_closed(n_ac, den_v)) ||
		        ((den_v != 0) && in_closed(ratio_r, bx_w) && in_closed(n_ad, den_v));
	end

	logic signed [PIX_W-1:0] ax_c, ay_c, bxp_c, byp_c;
	assign ax_c  = to_pix(prev_x_q);
	assign ay_c  = to_pix(prev_y_q);
	assign bxp_c = to_pix(cur_x_q);
	assign byp_c = to_pix(cur_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_l_q <= '0;
			bnd_t_q <= '0;
			bnd_r_q <= '0;
			bnd_b_q <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
			speed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BOUND_LEFT:   bnd_l_q <= cfg_data;
				REG_BOUND_TOP:    bnd_t_q <= cfg_data;
				REG_BOUND_RIGHT:  bnd_r_q <= cfg_data;
				REG_BOUND_BOTTOM: bnd_b_q <= cfg_data;
				REG_DIR_X:        dir_x_q <= cfg_data;
				REG_DIR_Y:        dir_y_q <= cfg_data;
				REG_SPEED:        speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			alive_q  <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			done_q   <= 1'b0;
			op_q     <= '0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q <= item;
						op_q   <= '0;
						res_q.hit <= 1'b0;
						case (item.cmd)
							CMD_LAUNCH: begin
								prev_x_q <= item.start_x;
								prev_y_q <= item.start_y;
								cur_x_q  <= item.start_x;
								cur_y_q  <= item.start_y;
								alive_q  <= 1'b1;
								res_q.is_active <= 1'b1;
								res_q.at_x <= item.start_x;
								res_q.at_y <= item.start_y;
								done_q <= 1'b1;
							end
							CMD_ADVANCE: begin
								if (alive_q) begin
									state_q <= ST_LOAD;
								end else begin
									res_q.is_active <= alive_q;
									res_q.at_x <= cur_x_q;
									res_q.at_y <= cur_y_q;
									done_q <= 1'b1;
								end
							end
							CMD_TEST: state_q <= ST_PREP;
							default: begin
								res_q.is_active <= alive_q;
								res_q.at_x <= cur_x_q;
								res_q.at_y <= cur_y_q;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PREP: begin
					bx_q  <= DIF_W'(bxp_c) - DIF_W'(ax_c);
					by_q  <= DIF_W'(byp_c) - DIF_W'(ay_c);
					dyt_q <= DIF_W'(ay_c) - DIF_W'(item_q.box_top);
					dyb_q <= DIF_W'(ay_c) - DIF_W'(item_q.box_bottom);
					dxl_q <= DIF_W'(ax_c) - DIF_W'(item_q.box_left);
					dxr_q <= DIF_W'(ax_c) - DIF_W'(item_q.box_right);
					w_q   <= PIX_W'(item_q.box_right) - PIX_W'(item_q.box_left);
					h_q   <= PIX_W'(item_q.box_bottom) - PIX_W'(item_q.box_top);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					mcand_q <= 48'(op_a);
					mag_q   <= op_b[MAG_W-1] ? MAG_W'(-op_b) : MAG_W'(op_b);
					neg_q   <= op_b[MAG_W-1];
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q   <= acc_nx;
					mcand_q <= mcand_q <<< 1;
					mag_q   <= mag_q >> 1;
					cnt_q   <= cnt_q + 5'd1;
					if (cnt_q == 5'(MAG_W - 1)) begin
						p_q[op_q] <= neg_q ? PROD_W'(-acc_nx) : PROD_W'(acc_nx);
						op_q <= op_q + OP_W'(1);
						state_q <= (op_q == op_last) ? ST_FIN : ST_LOAD;
					end
				end
				ST_FIN: begin
					if (item_q.cmd == CMD_ADVANCE) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						cur_x_q  <= nx_sat;
						cur_y_q  <= ny_sat;
						alive_q  <= !out_of_bounds;
						res_q.is_active <= !out_of_bounds;
						res_q.at_x <= nx_sat;
						res_q.at_y <= ny_sat;
					end else begin
						res_q.is_active <= alive_q;
						res_q.hit  <= hit_c;
						res_q.at_x <= cur_x_q;
						res_q.at_y <= cur_y_q;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

### sim/projectile_step_and_swept_box_hit_tb.sv
// ----------------------------------------------------------------------------
// projectile_step_and_swept_box_hit_tb - self-checking regression
// A queue of command words feeds a clocked driver with random gaps. A
// tracker model in the bench predicts every result word, and a clocked
// monitor compares each done word with the oldest prediction. Register
// settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module projectile_step_and_swept_box_hit_tb;
	import psbh_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	item_t                item = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [REG_W-1:0]     cfg_data = '0;

	projectile_step_and_swept_box_hit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// tracker model state and registers
	longint m_bl, m_bt, m_br, m_bb, m_dx, m_dy, m_spd;
	bit     m_alive;
	longint m_px, m_py, m_cx, m_cy;

	item_t   pending_cmds[$];
	result_t expected_words[$];
	int      mismatches = 0;
	int      gap = 0;
	int      cycles = 0;

	function automatic longint sat_pos(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	function automatic longint round_pixel(longint v);
		longint t;
		t = v + (64'sd1 <<< (POS_FRAC - 1));
		if (t >= 0) return t >>> POS_FRAC;
		return -((-t) >>> POS_FRAC);
	endfunction

	function automatic bit between(longint n, longint d);
		if (d > 0) return n >= 0 && n <= d;
		return n <= 0 && n >= d;
	endfunction

	function automatic bit crosses(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint dx, longint dy);
		longint n0, n1, den;
		n0  = (ay - cy) * (dx - cx) - (ax - cx) * (dy - cy);
		n1  = (ay - cy) * (bx - ax) - (ax - cx) * (by - ay);
		den = (bx - ax) * (dy - cy) - (by - ay) * (dx - cx);
		if (den == 0) return 1'b0;
		return between(n0, den) && between(n1, den);
	endfunction

	function automatic result_t track_step(item_t w);
		result_t r;
		longint  el, l, t, rt, b, ax, ay, bx, by;
		bit      h;
		h = 1'b0;
		if (w.cmd == CMD_LAUNCH) begin
			m_cx = longint'($signed(w.start_x));
			m_cy = longint'($signed(w.start_y));
			m_px = m_cx;
			m_py = m_cy;
			m_alive = 1'b1;
		end else if (w.cmd == CMD_ADVANCE) begin
			if (m_alive) begin
				el = longint'(w.elapsed);
				m_px = m_cx;
				m_py = m_cy;
				// arithmetic shift of a signed longint is a floor
				m_cx = sat_pos(m_cx + ((m_dx * m_spd * el) >>> DIR_FRAC));
				m_cy = sat_pos(m_cy + ((m_dy * m_spd * el) >>> DIR_FRAC));
				if (m_cx < m_bl * 256 || m_cx > m_br * 256 ||
						m_cy < m_bt * 256 || m_cy > m_bb * 256)
					m_alive = 1'b0;
			end
		end else if (w.cmd == CMD_TEST) begin
			l  = longint'($signed(w.box_left));
			t  = longint'($signed(w.box_top));
			rt = longint'($signed(w.box_right));
			b  = longint'($signed(w.box_bottom));
			ax = round_pixel(m_px);
			ay = round_pixel(m_py);
			bx = round_pixel(m_cx);
			by = round_pixel(m_cy);
			h = crosses(ax, ay, bx, by, l, t, rt, t) ||
				crosses(ax, ay, bx, by, l, b, rt, b) ||
				crosses(ax, ay, bx, by, l, t, l, b) ||
				crosses(ax, ay, bx, by, rt, t, rt, b);
		end
		r.is_active = m_alive;
		r.hit       = h;
		r.at_x      = m_cx[POS_W-1:0];
		r.at_y      = m_cy[POS_W-1:0];
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_words.push_back(track_step(item));
				start <= 1'b0;
				gap <= $urandom_range(0, 10);
			end else if (!start) begin
				if (gap > 0)
					gap <= gap - 1;
				else if (pending_cmds.size() > 0) begin
					item <= pending_cmds.pop_front();
					start <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				report("unexpected word", 1, 0);
			end else begin
				want = expected_words.pop_front();
				if (result.is_active !== want.is_active)
					report("is_active", result.is_active, want.is_active);
				if (result.hit !== want.hit)
					report("hit", result.hit, want.hit);
				if (result.at_x !== want.at_x)
					report("at_x", $signed(result.at_x), $signed(want.at_x));
				if (result.at_y !== want.at_y)
					report("at_y", $signed(result.at_y), $signed(want.at_y));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("projectile_step_and_swept_box_hit regression: fail");
			$finish;
		end
	end

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || start || expected_words.size() != 0 || busy);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[REG_W-1:0];
		case (idx)
			REG_BOUND_LEFT:   m_bl = longint'($signed(val[15:0]));
			REG_BOUND_TOP:    m_bt = longint'($signed(val[15:0]));
			REG_BOUND_RIGHT:  m_br = longint'($signed(val[15:0]));
			REG_BOUND_BOTTOM: m_bb = longint'($signed(val[15:0]));
			REG_DIR_X:        m_dx = longint'($signed(val[15:0]));
			REG_DIR_Y:        m_dy = longint'($signed(val[15:0]));
			REG_SPEED:        m_spd = longint'(val[15:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(longint bl, longint bt, longint br, longint bb,
			longint dx, longint dy, longint spd);
		wait_idle();
		write_reg(REG_BOUND_LEFT, bl);
		write_reg(REG_BOUND_TOP, bt);
		write_reg(REG_BOUND_RIGHT, br);
		write_reg(REG_BOUND_BOTTOM, bb);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_SPEED, spd);
	endtask

	function automatic item_t make_cmd(logic [1:0] c, longint sx, longint sy, int el,
			longint l, longint t, longint r, longint b);
		item_t w;
		w.cmd = c;
		w.start_x = sx[23:0];
		w.start_y = sy[23:0];
		w.elapsed = el[9:0];
		w.box_left = l[15:0];
		w.box_top = t[15:0];
		w.box_right = r[15:0];
		w.box_bottom = b[15:0];
		return w;
	endfunction

	function automatic item_t noise_cmd();
		logic [127:0] raw;
		item_t        w;
		raw = {$urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(item_t)-1:0];
		return w;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// one launch, a few advances and tests with boxes near the launch point
	task automatic push_flight();
		longint sx, sy, px, py, x0, y0;
		int     n;
		px = m_bl + $urandom_range(0, 32'(m_br - m_bl));
		py = m_bt + $urandom_range(0, 32'(m_bb - m_bt));
		sx = px * 256 + $urandom_range(0, 255);
		sy = py * 256 + $urandom_range(0, 255);
		pending_cmds.push_back(make_cmd(CMD_LAUNCH, sx, sy, 0, 0, 0, 0, 0));
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(0, 1))
				pending_cmds.push_back(make_cmd(CMD_ADVANCE, $urandom, $urandom,
					$urandom_range(0, 1023) >> $urandom_range(0, 8), 0, 0, 0, 0));
			x0 = px + $signed($urandom_range(0, 80)) - 40;
			y0 = py + $signed($urandom_range(0, 80)) - 40;
			pending_cmds.push_back(make_cmd(CMD_TEST, $urandom, $urandom, $urandom,
				clamp16(x0), clamp16(y0), clamp16(x0 + $urandom_range(0, 60)),
				clamp16(y0 + $urandom_range(0, 60))));
		end
	endtask

	initial begin
		longint bl, bt;
		m_bl = 0; m_bt = 0; m_br = 0; m_bb = 0; m_dx = 0; m_dy = 0; m_spd = 0;
		m_alive = 0; m_px = 0; m_py = 0; m_cx = 0; m_cy = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset registers: test while expired, advance while expired,
		// unused command, launch at the corners of the position range
		pending_cmds.push_back(make_cmd(CMD_TEST, 0, 0, 0, -5, -5, 5, 5));
		pending_cmds.push_back(make_cmd(CMD_ADVANCE, 0, 0, 1023, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(2'd3, -1, -1, 1023, -1, -1, -1, -1));
		pending_cmds.push_back(make_cmd(CMD_LAUNCH, 8388607, -8388608, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_LAUNCH, -8388608, 8388607, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_LAUNCH, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0));

		// full bounds, extreme direction and speed: saturation then expiry
		setup(-32768, -32768, 32767, 32767, 16384, -16384, 65535);
		write_reg(3'd7, 16'hffff);
		pending_cmds.push_back(make_cmd(CMD_LAUNCH, 8388000, -8388000, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_ADVANCE, 0, 0, 1023, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_TEST, 0, 0, 0, 32760, -32768, 32767, -32760));
		pending_cmds.push_back(make_cmd(CMD_ADVANCE, 0, 0, 1, 0, 0, 0, 0));

		// moderate motion: parallel edge, box crossed, box missed
		setup(-1000, -1000, 1000, 1000, 16384, 0, 256);
		pending_cmds.push_back(make_cmd(CMD_LAUNCH, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_ADVANCE, 0, 0, 20, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_TEST, 0, 0, 0, 5, -3, 8, 3));
		pending_cmds.push_back(make_cmd(CMD_TEST, 0, 0, 0, -10, 0, 40, 10));
		pending_cmds.push_back(make_cmd(CMD_TEST, 0, 0, 0, 30, 30, 40, 40));
		pending_cmds.push_back(make_cmd(CMD_TEST, 0, 0, 0, -32768, -32768, 32767, 32767));
		pending_cmds.push_back(make_cmd(CMD_LAUNCH, -128, 127, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_ADVANCE, 0, 0, 1023, 0, 0, 0, 0));

		for (int ph = 0; ph < 7; ph++) begin
			bl = -$signed($urandom_range(0, 3000));
			bt = -$signed($urandom_range(0, 3000));
			if (ph == 6)
				setup(-32768, -32768, 32767, 32767, -16384, 16384, 65535);
			else
				setup(bl, bt, bl + $urandom_range(0, 4000), bt + $urandom_range(0, 4000),
					$signed($urandom_range(0, 32768)) - 16384,
					$signed($urandom_range(0, 32768)) - 16384,
					(ph == 3) ? 0 : $urandom_range(0, 600));
			while (pending_cmds.size() < 70) begin
				if ($urandom_range(0, 6) == 0)
					pending_cmds.push_back(noise_cmd());
				else
					push_flight();
			end
		end

		wait_idle();
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("projectile_step_and_swept_box_hit regression: pass");
		else
			$display("projectile_step_and_swept_box_hit regression: fail");
		$finish;
	end

endmodule
